>>> rtl/nscc_pkg.sv
// Package: character codes, status and kind codes, and the line verdict type.
package nscc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_T      = 8'h54;

  localparam int HEADER_LEN = 6;
  localparam logic [2:0] POS_MAX = 3'd7;
  localparam logic [1:0] DIGITS_MAX = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_NO_STAR   = 2'd2,
    ST_MISMATCH  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_GGA   = 2'd0,
    KIND_RMC   = 2'd1,
    KIND_HDT   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  calc_checksum;
    logic [7:0]  recv_checksum;
    kind_t       sentence_kind;
    logic        talker_known;
  } verdict_t;

  function automatic logic [4:0] hex_of(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h37;
      return {1'b1, d[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

>>> rtl/nscc_line_tracker.sv
// Line tracker: per-line state and the verdict formed at the line feed.
module nscc_line_tracker
  import nscc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  output logic       line_end,
  output verdict_t   verdict
);

  logic [2:0] char_position;
  logic       start_good;
  logic       asterisk_seen;
  logic [7:0] running_xor;
  logic [7:0] hex_value;
  logic [1:0] hex_digits_taken;
  logic       hex_stopped;
  logic [7:0] header_chars [HEADER_LEN];

  logic [4:0] hex_digit;
  logic       kind_gga, kind_rmc, kind_hdt;

  assign line_end  = (data_byte == CH_LF);
  assign hex_digit = hex_of(data_byte);

  always_ff @(posedge clk) begin
    if (rst || (take && line_end)) begin
      char_position    <= 3'd0;
      start_good       <= 1'b0;
      asterisk_seen    <= 1'b0;
      running_xor      <= 8'd0;
      hex_value        <= 8'd0;
      hex_digits_taken <= 2'd0;
      hex_stopped      <= 1'b0;
      for (int i = 0; i < HEADER_LEN; i++) begin
        header_chars[i] <= 8'd0;
      end
    end else if (take) begin
      if (char_position < 3'(HEADER_LEN)) begin
        header_chars[char_position] <= data_byte;
      end
      if (char_position == 3'd0) begin
        start_good <= (data_byte == CH_DOLLAR) || (data_byte == CH_BANG);
      end else if (!asterisk_seen) begin
        if (data_byte == CH_STAR) begin
          asterisk_seen <= 1'b1;
        end else begin
          running_xor <= running_xor ^ data_byte;
        end
      end else if (!hex_stopped && hex_digits_taken < DIGITS_MAX) begin
        if (hex_digit[4]) begin
          hex_value        <= {hex_value[3:0], hex_digit[3:0]};
          hex_digits_taken <= hex_digits_taken + 2'd1;
        end else begin
          hex_stopped <= 1'b1;
        end
      end
      if (char_position != POS_MAX) begin
        char_position <= char_position + 3'd1;
      end
    end
  end

  assign kind_gga = header_chars[3] == CH_G && header_chars[4] == CH_G &&
                    header_chars[5] == CH_A;
  assign kind_rmc = header_chars[3] == CH_R && header_chars[4] == CH_M &&
                    header_chars[5] == CH_C;
  assign kind_hdt = header_chars[3] == CH_H && header_chars[4] == CH_D &&
                    header_chars[5] == CH_T;

  always_comb begin
    if (char_position == 3'd0 || !start_good) begin
      verdict.status = ST_BAD_START;
    end else if (!asterisk_seen) begin
      verdict.status = ST_NO_STAR;
    end else if (running_xor != hex_value) begin
      verdict.status = ST_MISMATCH;
    end else begin
      verdict.status = ST_OK;
    end

    if (kind_gga) begin
      verdict.sentence_kind = KIND_GGA;
    end else if (kind_rmc) begin
      verdict.sentence_kind = KIND_RMC;
    end else if (kind_hdt) begin
      verdict.sentence_kind = KIND_HDT;
    end else begin
      verdict.sentence_kind = KIND_OTHER;
    end

    verdict.talker_known = (header_chars[0] == CH_DOLLAR) && (
      (header_chars[1] == CH_G && header_chars[2] == CH_P) ||
      (header_chars[1] == CH_G && header_chars[2] == CH_N) ||
      (header_chars[1] == CH_G && header_chars[2] == CH_L) ||
      (header_chars[1] == CH_B && header_chars[2] == CH_D) ||
      (header_chars[1] == CH_G && header_chars[2] == CH_A));

    verdict.calc_checksum = running_xor;
    verdict.recv_checksum = hex_value;
  end

endmodule

>>> rtl/nmea_sentence_checksum_checker.sv
// Top level: byte intake, line tracker and the verdict output register.
//
// Takes one character per clock while in_ready is high; gives one verdict per
// line, in the cycle after the line feed is taken. Each item updates the line
// state as it is taken; the verdict is held in an output register, so bytes
// keep flowing while a verdict waits. in_ready drops only while a verdict is
// held and out_ready is low, since the next line feed would need that register.
module nmea_sentence_checksum_checker
  import nscc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] calc_checksum,
  output logic [7:0] recv_checksum,
  output logic [1:0] sentence_kind,
  output logic       talker_known
);

  logic     take;
  logic     line_end;
  verdict_t verdict;
  verdict_t result;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  nscc_line_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .line_end  (line_end),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && line_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && line_end) begin
      result <= verdict;
    end
  end

  assign status        = result.status;
  assign calc_checksum = result.calc_checksum;
  assign recv_checksum = result.recv_checksum;
  assign sentence_kind = result.sentence_kind;
  assign talker_known  = result.talker_known;

endmodule

>>> test/tb_top.sv
// Testbench for the NMEA sentence checksum checker: line stimulus, verdict prediction and checks.
`timescale 1ns / 1ps

module tb_top;
  import nscc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 6;
  localparam int IDLE_PCT       = 23;
  localparam int RANDOM_BYTES   = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [7:0] CH_CR  = 8'h0D;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] status;
  logic [7:0] calc_checksum;
  logic [7:0] recv_checksum;
  logic [1:0] sentence_kind;
  logic       talker_known;

  nmea_sentence_checksum_checker dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .calc_checksum (calc_checksum),
    .recv_checksum (recv_checksum),
    .sentence_kind (sentence_kind),
    .talker_known  (talker_known)
  );

  // Line state of the predictor
  logic [2:0] line_pos;
  logic       start_ok;
  logic       star_seen;
  logic [7:0] line_xor;
  logic [7:0] hex_acc;
  logic [1:0] hex_count;
  logic       hex_done;
  logic [7:0] header [HEADER_LEN];

  verdict_t   pending_verdicts [$];
  logic [7:0] line_bytes [$];

  bit quiet;
  bit hold_req;
  int fail_count;
  int bytes_sent;
  int lines_sent;
  int verdicts_seen;
  int status_seen [4];

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

  task automatic clear_line_state();
    line_pos  = '0;
    start_ok  = 1'b0;
    star_seen = 1'b0;
    line_xor  = '0;
    hex_acc   = '0;
    hex_count = '0;
    hex_done  = 1'b0;
    for (int i = 0; i < HEADER_LEN; i++) header[i] = '0;
  endtask

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    return -1;
  endfunction

  function automatic bit header_at(input int at, input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] c);
    return header[at] == a && header[at + 1] == b && header[at + 2] == c;
  endfunction

  task automatic advance_line_state(input logic [7:0] b);
    verdict_t v;
    int d;
    if (b == CH_LF) begin
      if (line_pos == 0 || !start_ok) v.status = ST_BAD_START;
      else if (!star_seen) v.status = ST_NO_STAR;
      else if (line_xor != hex_acc) v.status = ST_MISMATCH;
      else v.status = ST_OK;
      v.calc_checksum = line_xor;
      v.recv_checksum = hex_acc;
      if (header_at(3, CH_G, CH_G, CH_A)) v.sentence_kind = KIND_GGA;
      else if (header_at(3, CH_R, CH_M, CH_C)) v.sentence_kind = KIND_RMC;
      else if (header_at(3, CH_H, CH_D, CH_T)) v.sentence_kind = KIND_HDT;
      else v.sentence_kind = KIND_OTHER;
      v.talker_known = header_at(0, CH_DOLLAR, CH_G, CH_P) ||
                       header_at(0, CH_DOLLAR, CH_G, CH_N) ||
                       header_at(0, CH_DOLLAR, CH_G, CH_L) ||
                       header_at(0, CH_DOLLAR, CH_B, CH_D) ||
                       header_at(0, CH_DOLLAR, CH_G, CH_A);
      pending_verdicts = {pending_verdicts, v};
      clear_line_state();
    end else begin
      if (line_pos < HEADER_LEN) header[line_pos] = b;
      if (line_pos == 0) begin
        start_ok = (b == CH_DOLLAR || b == CH_BANG);
      end else if (!star_seen) begin
        if (b == CH_STAR) star_seen = 1'b1;
        else line_xor = line_xor ^ b;
      end else if (!hex_done && hex_count < DIGITS_MAX) begin
        d = hex_digit(b);
        if (d >= 0) begin
          hex_acc   = {hex_acc[3:0], 4'(d)};
          hex_count = hex_count + 2'd1;
        end else begin
          hex_done = 1'b1;
        end
      end
      if (line_pos < POS_MAX) line_pos = line_pos + 3'd1;
    end
  endtask

  // Enter and leave at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    advance_line_state(b);
    bytes_sent++;
    if (b == CH_LF) lines_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line_bytes();
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
  endtask

  function automatic logic [7:0] text_xor(input string s);
    logic [7:0] x;
    x = '0;
    for (int i = 1; i < s.len(); i++) x = x ^ s[i];
    return x;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'("0") + 8'(v);
    if ($urandom_range(0, 1)) return 8'("A") + 8'(v) - 8'd10;
    return 8'("a") + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] rand_upper();
    return 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_STAR);
    return b;
  endfunction

  task automatic build_random_line();
    int r;
    int keep;
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] head [$];
    line_bytes.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 6)) line_bytes = {line_bytes, 8'($urandom_range(0, 255))};
      line_bytes = {line_bytes, CH_LF};
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 70) b = CH_DOLLAR;
    else if (r < 90) b = CH_BANG;
    else b = rand_text_byte();
    line_bytes = {line_bytes, b};
    case ($urandom_range(0, 9))
      0: head = {head, CH_G, CH_P};
      1: head = {head, CH_G, CH_N};
      2: head = {head, CH_G, CH_L};
      3: head = {head, CH_B, CH_D};
      4: head = {head, CH_G, CH_A};
      5, 6: head = {head, CH_G, rand_upper()};
      7: head = {head, rand_upper(), rand_upper()};
      default: head = {head, rand_text_byte(), rand_text_byte()};
    endcase
    case ($urandom_range(0, 8))
      0, 1: head = {head, CH_G, CH_G, CH_A};
      2, 3: head = {head, CH_R, CH_M, CH_C};
      4, 5: head = {head, CH_H, CH_D, CH_T};
      6: head = {head, rand_upper(), rand_upper(), rand_upper()};
      7: head = {head, CH_G, CH_G, rand_upper()};
      default: head = {head, rand_text_byte(), rand_text_byte(), rand_text_byte()};
    endcase
    keep = ($urandom_range(0, 99) < 12) ? $urandom_range(0, 4) : 5;
    for (int i = 0; i < keep; i++) line_bytes = {line_bytes, head[i]};
    repeat ($urandom_range(0, 8)) line_bytes = {line_bytes, rand_text_byte()};
    sum = '0;
    for (int i = 1; i < line_bytes.size(); i++) sum = sum ^ line_bytes[i];
    if ($urandom_range(0, 99) < 92) begin
      line_bytes = {line_bytes, CH_STAR};
      r = $urandom_range(0, 99);
      if (r < 65 || (r >= 88 && r < 95)) begin
        line_bytes = {line_bytes, hex_char(sum[7:4]), hex_char(sum[3:0])};
        if (r >= 88) line_bytes = {line_bytes, hex_char(4'($urandom_range(0, 15)))};
      end else if (r < 75) begin
        line_bytes = {line_bytes, hex_char(4'($urandom_range(0, 15))),
                      hex_char(4'($urandom_range(0, 15)))};
      end else if (r < 83) begin
        line_bytes = {line_bytes, hex_char(4'($urandom_range(0, 15)))};
      end else if (r >= 95) begin
        line_bytes = {line_bytes, hex_char(sum[3:0]), rand_text_byte()};
      end
    end
    if ($urandom_range(0, 1)) line_bytes = {line_bytes, CH_CR};
    line_bytes = {line_bytes, CH_LF};
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: verdict %0d %s mismatch: expected %0h, actual %0h",
                 $realtime, verdicts_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected verdict, status %0h calc %0h recv %0h",
                   $realtime, status, calc_checksum, recv_checksum);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status", 8'(want.status), 8'(status));
        check_field("calc_checksum", want.calc_checksum, calc_checksum);
        check_field("recv_checksum", want.recv_checksum, recv_checksum);
        check_field("sentence_kind", 8'(want.sentence_kind), 8'(sentence_kind));
        check_field("talker_known", 8'(want.talker_known), 8'(talker_known));
        status_seen[want.status]++;
      end
      verdicts_seen++;
    end
  end

  // Receiver: random back-pressure, long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic test_reset();
    rst = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_text("\n");
    send_text("*\n");
    send_text("$G\n");
    send_text($sformatf("$GPGGA*%02x\n", text_xor("$GPGGA")));
    send_text("!*0\r\n");
    send_byte(CH_DOLLAR);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("*FF\n");
  endtask

  task automatic test_random_lines();
    int stop_at;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      build_random_line();
      send_line_bytes();
    end
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    repeat (15) begin
      build_random_line();
      send_line_bytes();
    end
    quiet = 1'b0;
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (12) begin
      build_random_line();
      send_line_bytes();
    end
  endtask

  initial begin
    in_valid   = 1'b0;
    data_byte  = '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    fail_count = 0;
    clear_line_state();
    test_reset();
    test_directed();
    test_random_lines();
    test_no_idle();
    test_output_stall();
    test_random_lines();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes in %0d lines, including idle-free and output-stall phases.",
             bytes_sent, lines_sent);
    $display("Checked %0d verdicts: %0d ok, %0d bad start, %0d no asterisk, %0d mismatch.",
             verdicts_seen, status_seen[ST_OK], status_seen[ST_BAD_START],
             status_seen[ST_NO_STAR], status_seen[ST_MISMATCH]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
